// ===== src/bsa_pkg.sv =====
`default_nettype none

package bsa_pkg;

	localparam int SLOT_COUNT  = 64;
	localparam int VALUE_WIDTH = 32;
	localparam int SLOT_W      = $clog2(SLOT_COUNT);
	localparam int INDEX_W     = 8;
	localparam int GRANT_W     = 6;
	localparam int READ_W      = 32;
	localparam int STORE_W     = 32;

	typedef enum logic [1:0] {
		OP_ALLOC = 2'd0,
		OP_FREE  = 2'd1,
		OP_GET   = 2'd2,
		OP_SET   = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_BAD_INDEX = 2'd2
	} status_t;

	// lowest free slot search result
	typedef struct packed {
		logic              found;
		logic [SLOT_W-1:0] slot;
	} ffz_t;

endpackage

`default_nettype wire

// ===== src/bsa_in_if.sv =====
`default_nettype none

interface bsa_in_if import bsa_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [1:0]         opcode;
	logic [INDEX_W-1:0] slot_index;
	logic [STORE_W-1:0] store_value;

	modport source (output valid, output opcode, output slot_index, output store_value,
		input ready);
	modport sink (input valid, input opcode, input slot_index, input store_value,
		output ready);
endinterface

`default_nettype wire

// ===== src/bsa_out_if.sv =====
`default_nettype none

interface bsa_out_if import bsa_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [1:0]         status;
	logic [GRANT_W-1:0] granted_slot;
	logic [READ_W-1:0]  read_value;

	modport source (output valid, output status, output granted_slot, output read_value,
		input ready);
	modport sink (input valid, input status, input granted_slot, input read_value,
		output ready);
endinterface

`default_nettype wire

// ===== src/bsa_ffz.sv =====
`default_nettype none

// priority encoder: lowest clear bit of the allocation map
module bsa_ffz import bsa_pkg::*; (
	input  wire logic [SLOT_COUNT-1:0] map,
	output ffz_t                       res
);

	always_comb begin
		res.found = ~&map;
		res.slot  = '0;
		for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
			if (!map[i]) begin
				res.slot = SLOT_W'(i);
			end
		end
	end

endmodule

`default_nettype wire

// ===== src/bitmap_slot_allocator_with_values.sv =====
// Bitmap slot allocator with one stored value per slot.
// cmd channel (sink): one beat per operation - opcode, slot_index, store_value.
//   allocate grants the lowest free slot and zeroes its value; free checks
//   range and allocation, then releases the slot; get and set check range only.
// rsp channel (source): exactly one beat per cmd beat, in order - status,
//   granted_slot, read_value.
// Path: a cmd beat is held in the s1 stage, then its result in the output register.
// Throughput: one beat per cycle unless rsp is held off. The slot values live in a
//   64 x 32 memory with one read port (read at accept) and one write port (written
//   at commit); a set directly followed by a get of the same slot is forwarded
//   around the memory.
// Reset: all slots free, all values read as zero. Per-slot valid flops stand in
//   for clearing the memory, so there is no clearing pass; cmd.ready rises
//   straight after reset.
// Stall: while rsp is held off the result sits in the output register and one
//   more beat is held in the s1 stage; cmd.ready drops only when both are full.
`default_nettype none

module bitmap_slot_allocator_with_values import bsa_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	bsa_in_if.sink    cmd,
	bsa_out_if.source rsp
);

	// s1 stage: captured operation plus registered memory read
	logic                   vld_s1;
	opcode_t                op_s1;
	logic [SLOT_W-1:0]      idx_s1;
	logic                   in_range_s1;
	logic [VALUE_WIDTH-1:0] val_s1;
	logic [VALUE_WIDTH-1:0] rdata_s1;

	// state
	logic [SLOT_COUNT-1:0]  map_q;      // allocation bitmap
	logic [SLOT_COUNT-1:0]  vld_q;      // value entry written since last clear
	logic [VALUE_WIDTH-1:0] mem [SLOT_COUNT];

	// result register
	logic                   rsp_vld_q;
	status_t                status_q;
	logic [GRANT_W-1:0]     grant_q;
	logic [READ_W-1:0]      read_q;

	logic                   commit;
	logic                   cmd_acc;
	logic                   cmd_in_range;
	logic                   fwd;
	ffz_t                   ffz;
	status_t                status_d;
	logic [GRANT_W-1:0]     grant_d;
	logic [READ_W-1:0]      read_d;
	logic                   map_set, map_clr, vld_clr, mem_wr;
	logic [SLOT_W-1:0]      clr_idx;

	// s1 moves on whenever the output register is free or being emptied
	assign commit    = vld_s1 && (!rsp_vld_q || rsp.ready);
	assign cmd.ready = !vld_s1 || commit;
	assign cmd_acc   = cmd.valid && cmd.ready;

	assign cmd_in_range = (32'(cmd.slot_index) < SLOT_COUNT);

	// set in s1 committing to the slot the incoming get reads: take the new value
	assign fwd = commit && (op_s1 == OP_SET) && in_range_s1 &&
		(opcode_t'(cmd.opcode) == OP_GET) && (cmd.slot_index[SLOT_W-1:0] == idx_s1);

	bsa_ffz u_ffz (
		.map (map_q),
		.res (ffz)
	);

	always_comb begin
		status_d = ST_OK;
		grant_d  = '0;
		read_d   = '0;
		map_set  = 1'b0;
		map_clr  = 1'b0;
		vld_clr  = 1'b0;
		mem_wr   = 1'b0;
		clr_idx  = idx_s1;
		case (op_s1)
			OP_ALLOC: begin
				if (ffz.found) begin
					map_set = 1'b1;
					vld_clr = 1'b1;
					clr_idx = ffz.slot;
					grant_d = GRANT_W'(ffz.slot);
				end else begin
					status_d = ST_FULL;
				end
			end
			OP_FREE: begin
				if (in_range_s1 && map_q[idx_s1]) begin
					map_clr = 1'b1;
					vld_clr = 1'b1;
				end else begin
					status_d = ST_BAD_INDEX;
				end
			end
			OP_GET: begin
				if (in_range_s1) begin
					read_d = vld_q[idx_s1] ? READ_W'(rdata_s1) : '0;
				end else begin
					status_d = ST_BAD_INDEX;
				end
			end
			OP_SET: begin
				if (in_range_s1) begin
					mem_wr = 1'b1;
				end else begin
					status_d = ST_BAD_INDEX;
				end
			end
			default: begin
				status_d = ST_BAD_INDEX;
			end
		endcase
	end

	// s1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (cmd.ready) begin
			vld_s1 <= cmd.valid;
		end
	end

	// s1 payload
	always_ff @(posedge clk) begin
		if (cmd_acc) begin
			op_s1       <= opcode_t'(cmd.opcode);
			idx_s1      <= cmd.slot_index[SLOT_W-1:0];
			in_range_s1 <= cmd_in_range;
			val_s1      <= VALUE_WIDTH'(cmd.store_value);
		end
	end

	// value memory: read at accept, write at commit
	always_ff @(posedge clk) begin
		if (cmd_acc) begin
			rdata_s1 <= fwd ? val_s1 : mem[cmd.slot_index[SLOT_W-1:0]];
		end
		if (commit && mem_wr) begin
			mem[idx_s1] <= val_s1;
		end
	end

	// map and value-valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_q <= '0;
			vld_q <= '0;
		end else if (commit) begin
			if (map_set) begin
				map_q[clr_idx] <= 1'b1;
			end
			if (map_clr) begin
				map_q[clr_idx] <= 1'b0;
			end
			if (vld_clr) begin
				vld_q[clr_idx] <= 1'b0;
			end
			if (mem_wr) begin
				vld_q[idx_s1] <= 1'b1;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_vld_q <= 1'b0;
		end else if (commit) begin
			rsp_vld_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			status_q <= status_d;
			grant_q  <= grant_d;
			read_q   <= read_d;
		end
	end

	assign rsp.valid        = rsp_vld_q;
	assign rsp.status       = status_q;
	assign rsp.granted_slot = grant_q;
	assign rsp.read_value   = read_q;

`ifndef ASSERT_OFF
	a_alloc_marks: assert property (@(posedge clk) disable iff (!arst_n)
		commit && (op_s1 == OP_ALLOC) && ffz.found |=> map_q[$past(ffz.slot)])
		else $error("allocated slot not marked used");

	a_full_only: assert property (@(posedge clk) disable iff (!arst_n)
		commit && (op_s1 == OP_ALLOC) && !ffz.found |-> &map_q)
		else $error("full reported with a free slot");

	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!rsp_vld_q |-> cmd.ready)
		else $error("cmd stalled with empty output register");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_vld_q && (status_q != ST_OK) |-> (grant_q == '0) && (read_q == '0))
		else $error("failed operation returned data");

	a_free_clears: assert property (@(posedge clk) disable iff (!arst_n)
		commit && map_clr |=> !map_q[$past(idx_s1)] && !vld_q[$past(idx_s1)])
		else $error("freed slot still marked");
`endif

endmodule

`default_nettype wire
